>>> rtl/core/ezrm_pkg.sv
// Package for the Euler Z-Y-X to rotation matrix block.
// Holds item types, CORDIC constants, the arctangent table and output rounding.
// No dependencies.
package ezrm_pkg;

    localparam int TABLE_LEN = 24;
    localparam int ANG_W     = 36;
    localparam int XY_W      = 34;
    localparam int SC_W      = 32;
    localparam int PROD_W    = 64;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [XY_W-1:0]  GAIN_INIT   = 34'sd652032874;
    localparam logic signed [17:0]      ONE_Q14     = 18'sd16384;

    typedef struct packed {
        logic signed [15:0] yaw_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } ezrm_angles_t;

    typedef struct packed {
        logic signed [15:0] elem_00;
        logic signed [15:0] elem_01;
        logic signed [15:0] elem_02;
        logic signed [15:0] elem_10;
        logic signed [15:0] elem_11;
        logic signed [15:0] elem_12;
        logic signed [15:0] elem_20;
        logic signed [15:0] elem_21;
        logic signed [15:0] elem_22;
    } ezrm_matrix_t;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] r;
        case (idx)
            0:       r = 32'h3243F6A8;
            1:       r = 32'h1DAC6705;
            2:       r = 32'h0FADBAFC;
            3:       r = 32'h07F56EA6;
            4:       r = 32'h03FEAB76;
            5:       r = 32'h01FFD55B;
            6:       r = 32'h00FFFAAA;
            7:       r = 32'h007FFF55;
            8:       r = 32'h003FFFEA;
            9:       r = 32'h001FFFFD;
            10:      r = 32'h000FFFFF;
            11:      r = 32'h0007FFFF;
            12:      r = 32'h0003FFFF;
            13:      r = 32'h0001FFFF;
            14:      r = 32'h0000FFFF;
            15:      r = 32'h00007FFF;
            16:      r = 32'h00003FFF;
            17:      r = 32'h00001FFF;
            18:      r = 32'h00000FFF;
            19:      r = 32'h000007FF;
            20:      r = 32'h000003FF;
            21:      r = 32'h000001FF;
            22:      r = 32'h000000FF;
            23:      r = 32'h0000007F;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] sat_q14(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > ONE_Q14)
        begin
            r = 16'sd16384;
        end
        else if (v < -ONE_Q14)
        begin
            r = -16'sd16384;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = (v + (64'sd1 <<< 45)) >>> 46;
        return sat_q14(t[17:0]);
    endfunction

endpackage

>>> rtl/core/ezrm_cordic_lane.sv
// Pipelined CORDIC sine/cosine lane: one angle per cycle, one stage per step.
// Depends on ezrm_pkg.
module ezrm_cordic_lane
    import ezrm_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                   clk,
    input  logic signed [15:0]     angle,
    output logic signed [SC_W-1:0] sin_val,
    output logic signed [SC_W-1:0] cos_val
);

    localparam int N = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;

    logic signed [XY_W-1:0]  x_reg [0:N];
    logic signed [XY_W-1:0]  y_reg [0:N];
    logic signed [ANG_W-1:0] z_reg [0:N];
    logic                    flip_reg [0:N];

    logic signed [ANG_W-1:0] z_in;
    logic signed [ANG_W-1:0] z_next;
    logic                    flip_next;

    assign z_in = {{3{angle[15]}}, angle, 17'b0};

    always_comb
    begin
        z_next    = z_in;
        flip_next = 1'b0;
        if (z_in > ANG_HALF_PI)
        begin
            z_next    = ANG_PI - z_in;
            flip_next = 1'b1;
        end
        else if (z_in < -ANG_HALF_PI)
        begin
            z_next    = -ANG_PI - z_in;
            flip_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= GAIN_INIT;
        y_reg[0]    <= '0;
        z_reg[0]    <= z_next;
        flip_reg[0] <= flip_next;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic signed [XY_W-1:0]  xs;
        logic signed [XY_W-1:0]  ys;
        logic signed [ANG_W-1:0] at;

        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        assign at = ANG_W'(atan_q30(i));

        always_ff @(posedge clk)
        begin
            if (!z_reg[i][ANG_W-1])
            begin
                x_reg[i+1] <= x_reg[i] - ys;
                y_reg[i+1] <= y_reg[i] + xs;
                z_reg[i+1] <= z_reg[i] - at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + ys;
                y_reg[i+1] <= y_reg[i] - xs;
                z_reg[i+1] <= z_reg[i] + at;
            end
            flip_reg[i+1] <= flip_reg[i];
        end
    end

    assign sin_val = y_reg[N][SC_W-1:0];
    assign cos_val = flip_reg[N] ? -x_reg[N][SC_W-1:0] : x_reg[N][SC_W-1:0];

endmodule

>>> rtl/core/ezrm_merge.sv
// Merging stage: multiplies lane sines and cosines into the nine matrix elements.
// Three register stages. Depends on ezrm_pkg.
module ezrm_merge
    import ezrm_pkg::*;
(
    input  logic                   clk,
    input  logic signed [SC_W-1:0] sy,
    input  logic signed [SC_W-1:0] cy,
    input  logic signed [SC_W-1:0] sp,
    input  logic signed [SC_W-1:0] cp,
    input  logic signed [SC_W-1:0] sr,
    input  logic signed [SC_W-1:0] cr,
    output ezrm_matrix_t           matrix
);

    logic signed [PROD_W-1:0] cycp_reg, sycp_reg, cycr_reg, cysr_reg, sycr_reg, sysr_reg;
    logic signed [PROD_W-1:0] cpsr_reg, cpcr_reg, cysp_reg, sysp_reg;
    logic signed [SC_W-1:0]   sr1_reg, cr1_reg;
    logic signed [15:0]       neg1_reg;
    logic signed [SC_W:0]     neg_full;
    logic signed [SC_W:0]     neg_sh;

    logic signed [PROD_W-1:0] cysp_rnd, sysp_rnd;
    logic signed [SC_W-1:0]   cysp30, sysp30;
    logic signed [PROD_W-1:0] t_cyspsr_reg, t_cyspcr_reg, t_syspsr_reg, t_syspcr_reg;
    logic signed [PROD_W-1:0] cycp2_reg, sycp2_reg, cycr2_reg, cysr2_reg, sycr2_reg;
    logic signed [PROD_W-1:0] sysr2_reg, cpsr2_reg, cpcr2_reg;
    logic signed [15:0]       neg2_reg;

    assign neg_full = -{sp[SC_W-1], sp} + (33'sd1 <<< 15);
    assign neg_sh   = neg_full >>> 16;

    always_ff @(posedge clk)
    begin
        cycp_reg <= cy * cp;
        sycp_reg <= sy * cp;
        cycr_reg <= cy * cr;
        cysr_reg <= cy * sr;
        sycr_reg <= sy * cr;
        sysr_reg <= sy * sr;
        cpsr_reg <= cp * sr;
        cpcr_reg <= cp * cr;
        cysp_reg <= cy * sp;
        sysp_reg <= sy * sp;
        sr1_reg  <= sr;
        cr1_reg  <= cr;
        neg1_reg <= sat_q14(neg_sh[17:0]);
    end

    assign cysp_rnd = (cysp_reg + (64'sd1 <<< 29)) >>> 30;
    assign sysp_rnd = (sysp_reg + (64'sd1 <<< 29)) >>> 30;
    assign cysp30   = cysp_rnd[SC_W-1:0];
    assign sysp30   = sysp_rnd[SC_W-1:0];

    always_ff @(posedge clk)
    begin
        t_cyspsr_reg <= cysp30 * sr1_reg;
        t_cyspcr_reg <= cysp30 * cr1_reg;
        t_syspsr_reg <= sysp30 * sr1_reg;
        t_syspcr_reg <= sysp30 * cr1_reg;
        cycp2_reg    <= cycp_reg;
        sycp2_reg    <= sycp_reg;
        cycr2_reg    <= cycr_reg;
        cysr2_reg    <= cysr_reg;
        sycr2_reg    <= sycr_reg;
        sysr2_reg    <= sysr_reg;
        cpsr2_reg    <= cpsr_reg;
        cpcr2_reg    <= cpcr_reg;
        neg2_reg     <= neg1_reg;
    end

    always_ff @(posedge clk)
    begin
        matrix.elem_00 <= to_q14(cycp2_reg);
        matrix.elem_01 <= to_q14(t_cyspsr_reg - sycr2_reg);
        matrix.elem_02 <= to_q14(t_cyspcr_reg + sysr2_reg);
        matrix.elem_10 <= to_q14(sycp2_reg);
        matrix.elem_11 <= to_q14(t_syspsr_reg + cycr2_reg);
        matrix.elem_12 <= to_q14(t_syspcr_reg - cysr2_reg);
        matrix.elem_20 <= neg2_reg;
        matrix.elem_21 <= to_q14(cpsr2_reg);
        matrix.elem_22 <= to_q14(cpcr2_reg);
    end

endmodule

>>> rtl/core/euler_zyx_to_rotation_matrix.sv
// Top level: Euler Z-Y-X angles to 3x3 rotation matrix.
// Uses ezrm_pkg, ezrm_cordic_lane and ezrm_merge.
//
// Usage:
//   Input channel: drive angles and raise start; the item is taken at a rising
//   edge with start high and busy low. busy is always low, so one item may be
//   given every cycle.
//   Output channel: done is high for one cycle while matrix holds the result.
//   Pipeline: with N = CORDIC_STEPS capped at 24, an accepted item passes the
//   fold register, one pipeline stage per CORDIC step in each of three angle
//   lanes, then three multiply/round stages in the merge.
//   Throughput: one item per cycle, set by the fully pipelined lanes and
//   multiplier stages.
//   Reset: clears the valid pipeline; items in flight are dropped.
//   The receiver cannot stall; results appear on their fixed cycle.
module euler_zyx_to_rotation_matrix
    import ezrm_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  ezrm_angles_t angles,
    output logic         done,
    output ezrm_matrix_t matrix
);

    localparam int N   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int LAT = N + 4;

    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    logic signed [SC_W-1:0] sy, cy, sp, cp, sr, cr;

    assign busy       = 1'b0;
    assign valid_next = {valid_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done = valid_reg[LAT-1];

    ezrm_cordic_lane #(.STEPS(N)) u_lane_yaw
    (
        .clk     (clk),
        .angle   (angles.yaw_angle),
        .sin_val (sy),
        .cos_val (cy)
    );

    ezrm_cordic_lane #(.STEPS(N)) u_lane_pitch
    (
        .clk     (clk),
        .angle   (angles.pitch_angle),
        .sin_val (sp),
        .cos_val (cp)
    );

    ezrm_cordic_lane #(.STEPS(N)) u_lane_roll
    (
        .clk     (clk),
        .angle   (angles.roll_angle),
        .sin_val (sr),
        .cos_val (cr)
    );

    ezrm_merge u_merge
    (
        .clk    (clk),
        .sy     (sy),
        .cy     (cy),
        .sp     (sp),
        .cp     (cp),
        .sr     (sr),
        .cr     (cr),
        .matrix (matrix)
    );

endmodule

>>> rtl/core/ezrm_checker.sv
// Port-level checker for euler_zyx_to_rotation_matrix, bound to the top level.
// Depends on ezrm_pkg.
module ezrm_checker
    import ezrm_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input ezrm_matrix_t matrix
);

    localparam int LAT = ((CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS) + 4;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_item_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(start, LAT) && $past(rst_n, LAT)) |-> !done)
        else $error("result without item");

    a_elem20_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (matrix.elem_20 <= 16'sd16384 && matrix.elem_20 >= -16'sd16384))
        else $error("elem_20 out of range");

endmodule

bind euler_zyx_to_rotation_matrix ezrm_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_ezrm_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .matrix (matrix)
);

>>> dv/euler_zyx_to_rotation_matrix_test.sv
// Testbench for euler_zyx_to_rotation_matrix: drives angle triples and checks
// every matrix against a behavioral CORDIC and fixed-point product model.
// Depends on ezrm_pkg and the block's RTL.
`timescale 1ns / 100ps

module euler_zyx_to_rotation_matrix_test;
    import ezrm_pkg::*;

    localparam int STEPS     = 16;
    localparam int LATENCY   = STEPS + 4;
    localparam int MAX_CYC   = 200000;
    localparam int N_RANDOM  = 480;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint HPI_Q30  = 64'sd1686629713;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint UNITY    = 64'sd16384;
    localparam int ANG_LIMIT = 25736;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    ezrm_angles_t angles;
    logic         done;
    ezrm_matrix_t matrix;

    ezrm_matrix_t expected_matrices[$];
    int           n_sent;
    int           n_checked;
    int           n_errors;
    int           cycle_count;
    longint       atan_rom[24];

    euler_zyx_to_rotation_matrix #(.CORDIC_STEPS(STEPS)) i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .angles (angles),
        .done   (done),
        .matrix (matrix)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        atan_rom = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                     64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                     64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                     64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                     64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                     64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    end

    function automatic longint floor_div(longint v, int n);
        return v >>> n;
    endfunction

    task automatic sine_cosine(input logic signed [15:0] ang, output longint s,
                               output longint c);
        longint z;
        longint x;
        longint y;
        longint xs;
        longint ys;
        bit     flip;
        z = longint'(ang) * 131072;
        x = GAIN_Q30;
        y = 0;
        flip = 1'b0;
        if (z > HPI_Q30)
        begin
            z = PI_Q30 - z;
            flip = 1'b1;
        end
        else if (z < -HPI_Q30)
        begin
            z = -PI_Q30 - z;
            flip = 1'b1;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            xs = floor_div(x, i);
            ys = floor_div(y, i);
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_rom[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_rom[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endtask

    function automatic longint clamp_unity(longint r);
        if (r > UNITY)
        begin
            return UNITY;
        end
        if (r < -UNITY)
        begin
            return -UNITY;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] round_q60(longint q60);
        return 16'(clamp_unity(floor_div(q60 + (64'sd1 <<< 45), 46)));
    endfunction

    function automatic longint mul_round_q30(longint a, longint b);
        return floor_div(a * b + (64'sd1 <<< 29), 30);
    endfunction

    task automatic compute_matrix(input ezrm_angles_t a, output ezrm_matrix_t m);
        longint sy;
        longint cy;
        longint sp;
        longint cp;
        longint sr;
        longint cr;
        longint cysp;
        longint sysp;
        sine_cosine(a.yaw_angle, sy, cy);
        sine_cosine(a.pitch_angle, sp, cp);
        sine_cosine(a.roll_angle, sr, cr);
        cysp = mul_round_q30(cy, sp);
        sysp = mul_round_q30(sy, sp);
        m.elem_00 = round_q60(cy * cp);
        m.elem_01 = round_q60(cysp * sr - sy * cr);
        m.elem_02 = round_q60(cysp * cr + sy * sr);
        m.elem_10 = round_q60(sy * cp);
        m.elem_11 = round_q60(sysp * sr + cy * cr);
        m.elem_12 = round_q60(sysp * cr - cy * sr);
        m.elem_20 = 16'(clamp_unity(floor_div(-sp + (64'sd1 <<< 15), 16)));
        m.elem_21 = round_q60(cp * sr);
        m.elem_22 = round_q60(cp * cr);
    endtask

    task automatic send_item(input ezrm_angles_t a);
        ezrm_matrix_t m;
        angles <= a;
        start  <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        compute_matrix(a, m);
        expected_matrices.push_back(m);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n)
        begin
            @(negedge clk);
        end
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        while (expected_matrices.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LATENCY + 4)
        begin
            @(negedge clk);
        end
    endtask

    function automatic ezrm_angles_t triple(int y, int p, int r);
        ezrm_angles_t a;
        a.yaw_angle   = 16'(y);
        a.pitch_angle = 16'(p);
        a.roll_angle  = 16'(r);
        return a;
    endfunction

    function automatic int rand_angle();
        return int'($urandom_range(2 * ANG_LIMIT)) - ANG_LIMIT;
    endfunction

    task automatic test_directed();
        int edges[8];
        edges = '{0, 1, -1, ANG_LIMIT, -ANG_LIMIT, 12868, -12868, 6434};
        send_item(triple(0, 0, 0));
        for (int i = 0; i < 8; i++)
        begin
            send_item(triple(edges[i], edges[(i + 3) % 8], edges[(i + 5) % 8]));
        end
        // gimbal lock at pitch of plus and minus pi/2
        send_item(triple(6434, 12868, -6434));
        send_item(triple(-6434, -12868, 6434));
        // angles beyond pi, including the full 16-bit extremes
        send_item(triple(32767, -32768, 32767));
        send_item(triple(-32768, 32767, -32768));
        send_item(triple(25737, -25737, 30000));
        send_item(triple(16'h5555, 16'hAAAA, 16'h7FFF));
        send_item(triple(16'hAAAA, 16'h5555, 16'h8000));
        idle_cycles(3);
        send_item(triple(12868, 12867, 12869));
        drain_pipeline();
    endtask

    task automatic test_random_bursts();
        int burst;
        int y;
        int p;
        int r;
        for (int i = 0; i < N_RANDOM; i += burst)
        begin
            burst = ($urandom_range(3) == 0) ? 30 : $urandom_range(1, 12);
            for (int k = 0; k < burst; k++)
            begin
                y = rand_angle();
                p = rand_angle();
                r = rand_angle();
                if ($urandom_range(9) == 0)
                begin
                    y = int'($urandom_range(16'hFFFF));
                    p = int'($urandom_range(16'hFFFF));
                    r = int'($urandom_range(16'hFFFF));
                end
                send_item(triple(y, p, r));
            end
            if ($urandom_range(40) == 0)
            begin
                drain_pipeline();
            end
            else if ($urandom_range(2) != 0)
            begin
                idle_cycles($urandom_range(1, 25));
            end
        end
        drain_pipeline();
    endtask

    always @(posedge clk)
    begin
        ezrm_matrix_t exp_m;
        if (rst_n && done)
        begin
            if (expected_matrices.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                begin
                    $display("unexpected result %h", matrix);
                end
            end
            else
            begin
                exp_m = expected_matrices.pop_front();
                n_checked++;
                if (matrix !== exp_m)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("mismatch item %0d", n_checked);
                        $display("  exp %h %h %h %h %h %h %h %h %h", exp_m.elem_00,
                                 exp_m.elem_01, exp_m.elem_02, exp_m.elem_10,
                                 exp_m.elem_11, exp_m.elem_12, exp_m.elem_20,
                                 exp_m.elem_21, exp_m.elem_22);
                        $display("  got %h %h %h %h %h %h %h %h %h", matrix.elem_00,
                                 matrix.elem_01, matrix.elem_02, matrix.elem_10,
                                 matrix.elem_11, matrix.elem_12, matrix.elem_20,
                                 matrix.elem_21, matrix.elem_22);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYC)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        angles      = '0;
        n_sent      = 0;
        n_checked   = 0;
        n_errors    = 0;
        cycle_count = 0;
        repeat (12)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_bursts();
        n_errors += expected_matrices.size();
        $display("sent %0d angle triples, checked %0d matrices", n_sent, n_checked);
        $display("covered edge angles, gimbal lock, out-of-range folding, bursts");
        if (n_errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/ezrm_pkg.sv
rtl/core/ezrm_cordic_lane.sv
rtl/core/ezrm_merge.sv
rtl/core/euler_zyx_to_rotation_matrix.sv
rtl/core/ezrm_checker.sv
dv/euler_zyx_to_rotation_matrix_test.sv
